[sv/b64sc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package b64sc_pkg;

    // Kinds of group command passed from the front to the back
    typedef enum logic [1:0] {
        KIND_ENC = 2'd0,
        KIND_DEC = 2'd1,
        KIND_ERR = 2'd2
    } t_kind;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;

    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // One completed group, with everything the back needs to emit its results
    typedef struct packed {
        t_kind       kind;
        logic [23:0] bits;
        logic [2:0]  cnt;    // results in this command, 1 to 4
        logic [2:0]  nreal;  // encode: characters before padding starts
        logic        last;
        logic [1:0]  status;
    } t_cmd;

    // Map a sextet to its alphabet character
    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < 6'd26) begin
            return 8'h41 + v8;
        end else if (v < 6'd52) begin
            return 8'h61 + v8 - 8'd26;
        end else if (v < 6'd62) begin
            return 8'h30 + v8 - 8'd52;
        end else if (v == 6'd62) begin
            return 8'h2B;
        end
        return 8'h2F;
    endfunction

    // Map a character to {not_in_alphabet, sextet}
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            return {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            return {1'b0, 6'd62};
        end else if (c == 8'h2F) begin
            return {1'b0, 6'd63};
        end
        return {1'b1, 6'd0};
    endfunction

endpackage

`default_nettype wire

[sv/base64_stream_codec.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         push / full            i_in_byte, i_in_last
// result    out        empty / pop            o_out_byte, o_out_last, o_status
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (direction)
//
// One input item is taken per cycle while the command queue has room; results
// leave the output register at one per cycle while the result side pops, so
// encoding gives four results per three bytes and decoding three or fewer per
// four characters. Each command goes via the queue into the output register.
// Reset is synchronous and clears group state, the queue and the output.
// A stalled result side fills the queue, after which full rises.

module base64_stream_codec #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data
);

    b64sc_pkg::t_cmd cmd_in, cmd_out;
    logic            cmd_push, cmd_pop, q_full, q_empty;
    logic            accept, out_valid, cfg_we;

    assign accept      = push && !q_full;
    assign full        = q_full;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign empty       = !out_valid;

    b64sc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_dir  (i_cfg_data),
        .i_accept   (accept),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_cmd      (cmd_in),
        .o_cmd_push (cmd_push)
    );

    b64sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    b64sc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_valid     (out_valid),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

[sv/b64sc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module b64sc_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_dir,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_in_byte,
    input  wire logic           i_in_last,
    output b64sc_pkg::t_cmd     o_cmd,
    output logic                o_cmd_push
);

    logic        r_dir;
    logic [23:0] r_bits, n_bits;
    logic [1:0]  r_pos, n_pos;
    logic        r_prev_pad, n_prev_pad;
    logic        r_bad, n_bad;

    logic [2:0]  held;
    logic [6:0]  dec;
    logic        is_pad;
    logic        bad_now;
    logic [5:0]  sext;

    // Classify the incoming character
    always_comb begin
        dec     = b64sc_pkg::char_to_sextet(i_in_byte);
        is_pad  = (i_in_byte == b64sc_pkg::CHAR_PAD);
        bad_now = dec[6] && !is_pad;
        sext    = is_pad ? 6'd0 : dec[5:0];
        held    = {1'b0, r_pos} + 3'd1;
    end

    // Assemble the group and issue a command when it completes
    always_comb begin
        n_bits     = r_bits;
        n_pos      = r_pos;
        n_prev_pad = r_prev_pad;
        n_bad      = r_bad;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        if (i_accept) begin
            if (!r_dir) begin
                o_cmd.kind = b64sc_pkg::KIND_ENC;
                o_cmd.bits = r_bits;
                case (r_pos)
                    2'd0:    o_cmd.bits[23:16] = i_in_byte;
                    2'd1:    o_cmd.bits[15:8]  = i_in_byte;
                    default: o_cmd.bits[7:0]   = i_in_byte;
                endcase
                o_cmd.cnt    = 3'd4;
                o_cmd.nreal  = held + 3'd1;
                o_cmd.last   = i_in_last;
                o_cmd.status = b64sc_pkg::ST_OK;
                if (held == 3'd3 || i_in_last) begin
                    o_cmd_push = 1'b1;
                    n_bits     = '0;
                    n_pos      = '0;
                end else begin
                    n_bits = o_cmd.bits;
                    n_pos  = held[1:0];
                end
            end else begin
                o_cmd.bits  = {r_bits[17:0], sext};
                o_cmd.nreal = 3'd0;
                o_cmd.last  = i_in_last;
                if (held != 3'd4) begin
                    if (i_in_last) begin
                        // Message ended inside a group
                        o_cmd_push   = 1'b1;
                        o_cmd.kind   = b64sc_pkg::KIND_ERR;
                        o_cmd.bits   = '0;
                        o_cmd.cnt    = 3'd1;
                        o_cmd.status = b64sc_pkg::ST_BAD_LEN;
                        n_bits       = '0;
                        n_pos        = '0;
                        n_prev_pad   = 1'b0;
                        n_bad        = 1'b0;
                    end else begin
                        n_bits     = o_cmd.bits;
                        n_pos      = held[1:0];
                        n_prev_pad = is_pad;
                        n_bad      = r_bad || bad_now;
                    end
                end else begin
                    o_cmd_push   = 1'b1;
                    o_cmd.kind   = b64sc_pkg::KIND_DEC;
                    o_cmd.cnt    = i_in_last
                                 ? 3'd3 - {2'b00, is_pad} - {2'b00, r_prev_pad}
                                 : 3'd3;
                    o_cmd.status = (r_bad || bad_now) ? b64sc_pkg::ST_BAD_CHAR
                                                      : b64sc_pkg::ST_OK;
                    n_bits       = '0;
                    n_pos        = '0;
                    n_prev_pad   = 1'b0;
                    n_bad        = 1'b0;
                end
            end
        end
    end

    // Hold direction and group state; a direction write clears the group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir      <= 1'b0;
            r_bits     <= '0;
            r_pos      <= '0;
            r_prev_pad <= 1'b0;
            r_bad      <= 1'b0;
        end else if (i_cfg_we) begin
            r_dir      <= i_cfg_dir;
            r_bits     <= '0;
            r_pos      <= '0;
            r_prev_pad <= 1'b0;
            r_bad      <= 1'b0;
        end else begin
            r_bits     <= n_bits;
            r_pos      <= n_pos;
            r_prev_pad <= n_prev_pad;
            r_bad      <= n_bad;
        end
    end

    // An encode group never holds more than two bytes between items
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dir |-> r_pos != 2'd3)
        else $error("encode group position out of range");

endmodule

`default_nettype wire

[sv/b64sc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module b64sc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire b64sc_pkg::t_cmd i_data,
    input  wire logic            i_pop,
    output b64sc_pkg::t_cmd      o_data,
    output logic                 o_full,
    output logic                 o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64sc_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command pushed into full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("command popped from empty queue");

endmodule

`default_nettype wire

[sv/b64sc_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module b64sc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire b64sc_pkg::t_cmd i_cmd,
    input  wire logic            i_cmd_empty,
    output logic                 o_cmd_pop,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_last,
    output logic [1:0]           o_status
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_last;
    logic [1:0] r_status;
    logic       take;
    logic       at_end;
    logic [5:0] sext;
    logic [7:0] dbyte;

    assign take      = !i_cmd_empty && (!r_valid || i_pop);
    assign at_end    = ({1'b0, r_idx} == i_cmd.cnt - 3'd1);
    assign o_cmd_pop = take && at_end;

    // Pick the sextet and byte at the current index
    always_comb begin
        case (r_idx)
            2'd0:    sext = i_cmd.bits[23:18];
            2'd1:    sext = i_cmd.bits[17:12];
            2'd2:    sext = i_cmd.bits[11:6];
            default: sext = i_cmd.bits[5:0];
        endcase
        case (r_idx)
            2'd0:    dbyte = i_cmd.bits[23:16];
            2'd1:    dbyte = i_cmd.bits[15:8];
            default: dbyte = i_cmd.bits[7:0];
        endcase
    end

    // Form the result for the current index
    always_comb begin
        unique case (i_cmd.kind)
            b64sc_pkg::KIND_ENC:
                n_byte = ({1'b0, r_idx} >= i_cmd.nreal) ? b64sc_pkg::CHAR_PAD
                                                        : b64sc_pkg::sextet_to_char(sext);
            b64sc_pkg::KIND_DEC: n_byte = dbyte;
            default:             n_byte = 8'd0;
        endcase
    end

    // Advance the index and load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte   <= n_byte;
            r_last   <= i_cmd.last && at_end;
            r_status <= i_cmd.status;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_out_last = r_last;
    assign o_status   = r_status;

    // A length error is always a lone, final result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == b64sc_pkg::ST_BAD_LEN) |-> (r_last && r_byte == 8'd0))
        else $error("length error result malformed");

    // The index never runs past the command's result count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_empty |-> ({1'b0, r_idx} < i_cmd.cnt))
        else $error("result index beyond command count");

endmodule

`default_nettype wire
